// File: design/mqttrd_pkg.sv
package mqttrd_pkg;

   localparam int MAX_LENGTH_BYTES = 4;

   localparam logic [1:0] KIND_TOPIC     = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
   localparam logic [1:0] KIND_CONNACK   = 2'd2;
   localparam logic [1:0] KIND_MALFORMED = 2'd3;

   localparam logic [3:0] PTYPE_CONNACK = 4'd2;
   localparam logic [3:0] PTYPE_PUBLISH = 4'd3;

   localparam logic [7:0] CONNACK_NONE = 8'hFF;

   typedef struct packed {
      logic       vld;
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } res_type;

endpackage

// File: design/mqttrd_parse.sv
module mqttrd_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [7:0]         rx_byte,
   output mqttrd_pkg::res_type res
);
   import mqttrd_pkg::*;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_LENGTH = 3'd1;
   localparam logic [2:0] PH_BODY   = 3'd2;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  header_ff, header_in;
   logic [27:0] rlen_ff, rlen_in;
   logic [1:0]  lidx_ff, lidx_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [27:0] bcnt_ff, bcnt_in;
   logic [7:0]  cack_ff, cack_in;
   logic        dlv_ff, dlv_in;

   logic [3:0]  ptype;
   logic [1:0]  skip;
   logic [4:0]  shamt;
   logic [27:0] rlen_or;
   logic [28:0] pos1;
   logic        pkt_end;
   logic [16:0] topic_end;
   logic [17:0] pay_start;
   logic [15:0] tlen_new;
   logic [17:0] offset;

   assign ptype     = header_ff[7:4];
   assign skip      = (header_ff[2:1] != 2'b00) ? 2'd2 : 2'd0;
   assign shamt     = 5'(lidx_ff) * 5'd7;
   assign rlen_or   = rlen_ff | (28'(rx_byte[6:0]) << shamt);
   assign pos1      = {1'b0, bcnt_ff} + 29'd1;
   assign pkt_end   = pos1 >= {1'b0, rlen_ff};
   assign topic_end = {1'b0, tlen_ff} + 17'd2;
   assign pay_start = {2'b00, tlen_ff} + 18'd2 + 18'(skip);
   assign tlen_new  = tlen_ff | {8'h00, rx_byte};
   assign offset    = {2'b00, tlen_new} + 18'd2 + 18'(skip);

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      rlen_in   = rlen_ff;
      lidx_in   = lidx_ff;
      tlen_in   = tlen_ff;
      bcnt_in   = bcnt_ff;
      cack_in   = cack_ff;
      dlv_in    = dlv_ff;
      res       = '0;
      unique case (phase_ff)
         PH_LENGTH: begin
            rlen_in = rlen_or;
            if (!rx_byte[7]) begin
               bcnt_in = '0;
               if (rlen_or == 28'd0) begin
                  phase_in = PH_HEADER;
                  if (ptype == PTYPE_CONNACK) begin
                     res.vld  = 1'b1;
                     res.kind = KIND_CONNACK;
                     res.data = CONNACK_NONE;
                  end
               end else begin
                  phase_in = PH_BODY;
               end
            end else if (3'(lidx_ff) + 3'd1 >= 3'(MAX_LENGTH_BYTES)) begin
               phase_in = PH_HEADER;
               res.vld  = 1'b1;
               res.kind = KIND_MALFORMED;
            end else begin
               lidx_in = lidx_ff + 2'd1;
            end
         end
         PH_BODY: begin
            if (ptype == PTYPE_CONNACK) begin
               if (bcnt_ff == 28'd1) cack_in = rx_byte;
               if (pkt_end) begin
                  res.vld  = 1'b1;
                  res.kind = KIND_CONNACK;
                  res.data = (bcnt_ff == 28'd1) ? rx_byte : cack_ff;
               end
            end else if (ptype == PTYPE_PUBLISH) begin
               if (bcnt_ff == 28'd0) begin
                  tlen_in = {rx_byte, 8'h00};
               end else if (bcnt_ff == 28'd1) begin
                  tlen_in = tlen_new;
                  dlv_in  = (rlen_ff >= 28'd4) && (rlen_ff > 28'(offset));
               end else if (dlv_ff) begin
                  if (bcnt_ff < 28'(topic_end)) begin
                     res.vld  = 1'b1;
                     res.kind = KIND_TOPIC;
                     res.data = rx_byte;
                  end else if (bcnt_ff >= 28'(pay_start)) begin
                     res.vld  = 1'b1;
                     res.kind = KIND_PAYLOAD;
                     res.data = rx_byte;
                     res.last = pkt_end;
                  end
               end
            end
            bcnt_in = pos1[27:0];
            if (pkt_end) phase_in = PH_HEADER;
         end
         default: begin
            header_in = rx_byte;
            rlen_in   = '0;
            lidx_in   = '0;
            tlen_in   = '0;
            bcnt_in   = '0;
            cack_in   = CONNACK_NONE;
            dlv_in    = 1'b0;
            phase_in  = PH_LENGTH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         header_ff <= '0;
         rlen_ff   <= '0;
         lidx_ff   <= '0;
         tlen_ff   <= '0;
         bcnt_ff   <= '0;
         cack_ff   <= CONNACK_NONE;
         dlv_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         rlen_ff   <= rlen_in;
         lidx_ff   <= lidx_in;
         tlen_ff   <= tlen_in;
         bcnt_ff   <= bcnt_in;
         cack_ff   <= cack_in;
         dlv_ff    <= dlv_in;
      end
   end

endmodule

// File: design/mqtt_receive_deframer.sv
// A byte taken on the request side passes through the input register and then
// the result register before its result appears on rsp_valid.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or its transfer completes in the same cycle.
// Reset (synchronous, active high) clears both valid flags and returns the
// parser to waiting for a header byte.
module mqtt_receive_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_last
);
   import mqttrd_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       out_vld_ff, out_vld_in;
   logic [1:0] out_kind_ff;
   logic [7:0] out_data_ff;
   logic       out_last_ff;
   logic       p_adv;
   logic       req_take;
   res_type    res;

   assign p_adv     = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !p_adv;
   assign req_take  = req_valid && !req_stall;

   mqttrd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (p_adv),
      .rx_byte (in_byte_ff),
      .res     (res)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take)   in_vld_in = 1'b1;
      else if (p_adv) in_vld_in = 1'b0;
      out_vld_in = out_vld_ff;
      if (p_adv)           out_vld_in = res.vld;
      else if (!rsp_stall) out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_byte_ff <= req_rx_byte;
      if (p_adv && res.vld) begin
         out_kind_ff <= res.kind;
         out_data_ff <= res.data;
         out_last_ff <= res.last;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_data  = out_data_ff;
   assign rsp_last  = out_last_ff;

`ifndef SYNTH
   a_last_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == KIND_PAYLOAD)
      else $error("last flag on non-payload transfer");

   a_malformed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_MALFORMED |-> rsp_data == 8'h00 && !rsp_last)
      else $error("malformed result carries data");

   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && out_vld_ff && rsp_stall)
      else $error("input stalled without a blocked result");
`endif

endmodule

// File: dv/testbench.sv
module testbench;
   import mqttrd_pkg::*;

   typedef logic [7:0] byte_q_type[$];

   typedef enum logic [2:0] {
      WAIT_HDR  = 3'd0,
      READ_LEN  = 3'd1,
      READ_BODY = 3'd2
   } parse_phase_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data;
   logic       rsp_last;

   // parser state mirrored on the testbench side
   parse_phase_type ph;
   logic [7:0]   hdr_byte;
   logic [31:0]  rem_len;
   logic [1:0]   len_idx;
   logic [15:0]  topic_len;
   logic [31:0]  body_cnt;
   logic [7:0]   ack_code;
   bit           deliver;

   res_type     pending_deframed[$];
   int          err_cnt       = 0;
   int unsigned bytes_sent    = 0;
   bit          idle_on       = 1'b1;
   int unsigned pressure_req  = 0;
   int unsigned pressure_seen = 0;
   int unsigned hold_left     = 0;

   mqtt_receive_deframer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_kind    (rsp_kind),
      .rsp_data    (rsp_data),
      .rsp_last    (rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic bit deframe_byte(input logic [7:0] b, output res_type r);
      logic [3:0]  ptype;
      logic [1:0]  idx;
      logic [31:0] pos;
      logic [31:0] skip;
      logic [31:0] offset;
      bit          at_end;
      bit          hit;
      ptype = hdr_byte[7:4];
      r = '0;
      r.vld = 1'b1;
      hit = 1'b0;
      case (ph)
         READ_LEN: begin
            idx = len_idx;
            rem_len = (rem_len | (32'(b[6:0]) << (7 * int'(idx)))) & 32'h0FFF_FFFF;
            if (!b[7]) begin
               body_cnt = 0;
               if (rem_len == 0) begin
                  ph = WAIT_HDR;
                  if (ptype == PTYPE_CONNACK) begin
                     r.kind = KIND_CONNACK;
                     r.data = CONNACK_NONE;
                     hit = 1'b1;
                  end
               end else begin
                  ph = READ_BODY;
               end
            end else if (int'(idx) + 1 >= MAX_LENGTH_BYTES) begin
               ph = WAIT_HDR;
               r.kind = KIND_MALFORMED;
               r.data = 8'h00;
               hit = 1'b1;
            end else begin
               len_idx = idx + 2'd1;
            end
         end
         READ_BODY: begin
            pos = body_cnt;
            at_end = (pos + 1 >= rem_len);
            if (ptype == PTYPE_CONNACK) begin
               if (pos == 1)
                  ack_code = b;
               if (at_end) begin
                  r.kind = KIND_CONNACK;
                  r.data = ack_code;
                  hit = 1'b1;
               end
            end else if (ptype == PTYPE_PUBLISH) begin
               skip = (hdr_byte[2:1] != 2'b00) ? 2 : 0;
               if (pos == 0) begin
                  topic_len = {b, 8'h00};
               end else if (pos == 1) begin
                  topic_len = {topic_len[15:8], b};
                  offset = 2 + topic_len + skip;
                  deliver = (rem_len >= 4) && (rem_len > offset);
               end else if (deliver) begin
                  if (pos < 2 + topic_len) begin
                     r.kind = KIND_TOPIC;
                     r.data = b;
                     hit = 1'b1;
                  end else if (pos >= 2 + topic_len + skip) begin
                     r.kind = KIND_PAYLOAD;
                     r.data = b;
                     r.last = at_end;
                     hit = 1'b1;
                  end
               end
            end
            body_cnt = (pos + 1) & 32'h0FFF_FFFF;
            if (at_end)
               ph = WAIT_HDR;
         end
         default: begin
            hdr_byte = b;
            rem_len = '0;
            len_idx = '0;
            topic_len = '0;
            body_cnt = '0;
            ack_code = CONNACK_NONE;
            deliver = 1'b0;
            ph = READ_LEN;
         end
      endcase
      return hit;
   endfunction

   function automatic byte_q_type length_bytes(int unsigned len, int unsigned min_bytes);
      byte_q_type q;
      int unsigned v;
      v = len;
      forever begin
         if (v < 128 && q.size() + 1 >= min_bytes) begin
            q.push_back(8'(v));
            break;
         end
         q.push_back(8'h80 | 8'(v & 127));
         v = v >> 7;
      end
      return q;
   endfunction

   // header, length (sometimes padded with empty continuation groups), body
   function automatic byte_q_type frame(logic [7:0] hdr, byte_q_type body);
      byte_q_type pkt;
      byte_q_type len_q;
      int unsigned min_bytes;
      min_bytes = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_LENGTH_BYTES) : 1;
      len_q = length_bytes(body.size(), min_bytes);
      pkt.push_back(hdr);
      foreach (len_q[i])
         pkt.push_back(len_q[i]);
      foreach (body[i])
         pkt.push_back(body[i]);
      return pkt;
   endfunction

   function automatic byte_q_type publish_packet();
      byte_q_type body;
      logic [7:0] hdr;
      int unsigned tl;
      int unsigned pl;
      int unsigned sel;
      hdr = {PTYPE_PUBLISH, 4'($urandom_range(0, 15))};
      tl = $urandom_range(0, 6);
      sel = $urandom_range(0, 99);
      if (sel < 15)
         pl = 0;
      else if (sel < 19)
         pl = $urandom_range(150, 250);
      else
         pl = $urandom_range(1, 12);
      if ($urandom_range(9) == 0) begin
         body.push_back(8'($urandom_range(0, 255)));
         body.push_back(8'($urandom_range(0, 255)));
      end else begin
         body.push_back(8'(tl >> 8));
         body.push_back(8'(tl));
      end
      repeat (tl)
         body.push_back(8'($urandom_range(0, 255)));
      if (hdr[2:1] != 2'b00)
         repeat (2) body.push_back(8'($urandom_range(0, 255)));
      repeat (pl)
         body.push_back(8'($urandom_range(0, 255)));
      return frame(hdr, body);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      res_type r;
      if (idle_on && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      if (deframe_byte(b, r))
         pending_deframed.push_back(r);
      bytes_sent++;
   endtask

   // finish any partial packet so the next one starts on a header byte
   task automatic sync_parser();
      while (ph != WAIT_HDR)
         send_byte(ph == READ_LEN ? 8'h00 : 8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_packet();
      byte_q_type body;
      byte_q_type pkt;
      logic [7:0] hdr;
      int unsigned pick;
      int unsigned cut;
      int unsigned n;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         pkt = publish_packet();
      end else if (pick < 60) begin
         hdr = {PTYPE_CONNACK, 4'($urandom_range(0, 15))};
         n = ($urandom_range(9) < 7) ? 2 : $urandom_range(0, 4);
         repeat (n) body.push_back(8'($urandom_range(0, 255)));
         pkt = frame(hdr, body);
      end else if (pick < 75) begin
         do hdr = 8'($urandom_range(0, 255));
         while (hdr[7:4] == PTYPE_CONNACK || hdr[7:4] == PTYPE_PUBLISH);
         repeat ($urandom_range(0, 8)) body.push_back(8'($urandom_range(0, 255)));
         pkt = frame(hdr, body);
      end else if (pick < 85) begin
         pkt.push_back(8'($urandom_range(0, 255)));
         repeat (MAX_LENGTH_BYTES) pkt.push_back(8'h80 | 8'($urandom_range(0, 127)));
      end else if (pick < 93) begin
         pkt = publish_packet();
         cut = $urandom_range(1, pkt.size() - 1);
         while (pkt.size() > cut)
            void'(pkt.pop_back());
      end else begin
         // noise kept below 0x80 so any length it forms stays short
         repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(0, 127)));
      end
      foreach (pkt[i])
         send_byte(pkt[i]);
      sync_parser();
   endtask

   task automatic test_directed();
      byte_q_type seq;
      seq = '{8'h20, 8'h02, 8'h00, 8'h05,
              8'h20, 8'h00,
              8'h32, 8'h06, 8'h00, 8'h01, 8'h7F, 8'hAA, 8'h55, 8'h80,
              8'h30, 8'h02, 8'hFF, 8'hFF,
              8'hF0, 8'h80, 8'h80, 8'h80, 8'h80,
              8'hD0, 8'h00};
      foreach (seq[i])
         send_byte(seq[i]);
   endtask

   task automatic test_random(input bit idle, input int unsigned until_bytes);
      idle_on = idle;
      while (bytes_sent < until_bytes)
         send_random_packet();
   endtask

   task automatic test_backpressure();
      byte_q_type body;
      byte_q_type pkt;
      idle_on = 1'b0;
      pressure_req++;
      body = '{8'h00, 8'h02, 8'h61, 8'h62};
      repeat (60) body.push_back(8'($urandom_range(0, 255)));
      pkt = frame({PTYPE_PUBLISH, 4'h0}, body);
      foreach (pkt[i])
         send_byte(pkt[i]);
      repeat (5) send_random_packet();
   endtask

   task automatic test_max_length();
      byte_q_type seq;
      idle_on = 1'b1;
      seq = '{{PTYPE_PUBLISH, 4'h0}, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h03};
      repeat (23) seq.push_back(8'($urandom_range(0, 255)));
      foreach (seq[i])
         send_byte(seq[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (pressure_seen != pressure_req) begin
         pressure_seen <= pressure_req;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 31);
      end
   end

   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_deframed.size() == 0) begin
            $error("unexpected transfer: kind %0d data %02h last %0b",
                   rsp_kind, rsp_data, rsp_last);
            err_cnt++;
         end else begin
            want = pending_deframed.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               err_cnt++;
            end
            if (rsp_data !== want.data) begin
               $error("data: expected %02h, got %02h", want.data, rsp_data);
               err_cnt++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               err_cnt++;
            end
         end
      end
   end

   initial begin
      ph = WAIT_HDR;
      hdr_byte = 8'h00;
      rem_len = '0;
      len_idx = '0;
      topic_len = '0;
      body_cnt = '0;
      ack_code = CONNACK_NONE;
      deliver = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1'b1, 700);
      test_random(1'b0, 1100);
      test_backpressure();
      test_random(1'b1, 1650);
      test_max_length();
      req_valid <= 1'b0;
      while (pending_deframed.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_cnt == 0 && pending_deframed.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: mqtt_receive_deframer.f
design/mqttrd_pkg.sv
design/mqttrd_parse.sv
design/mqtt_receive_deframer.sv
dv/testbench.sv
